### rtl/core/multi_dim_scatter_put_core_defines.svh
// Assertion macros shared by the scatter put core
`ifndef MULTI_DIM_SCATTER_PUT_CORE_DEFINES_SVH
`define MULTI_DIM_SCATTER_PUT_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define MDSP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mdsp_pkg.sv
// Types and constants of the scatter put core
package mdsp_pkg;

   localparam int NUM_DIMS   = 6;
   localparam int POS_W      = 13;
   localparam int SIZE_W     = 13;
   localparam int IDX_W      = 13;
   localparam int LIN_W      = 12;
   localparam int VALUE_W    = 32;
   localparam int RD_W       = 32;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   typedef logic [OP_W-1:0]         op_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [SIZE_W-1:0]       size_type;
   typedef logic [LIN_W-1:0]        lin_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [RD_W-1:0]  rd_type;
   typedef logic [CSR_IDX_W-1:0]    csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;
   typedef logic [2:0]              dim_idx_type;

   localparam op_type OP_LOAD    = 2'd0;
   localparam op_type OP_SCATTER = 2'd1;
   localparam op_type OP_READ    = 2'd2;

   localparam csr_idx_type CSR_SIZE_DIM0  = 3'd0;
   localparam csr_idx_type CSR_ACCUM_MODE = 3'd6;

endpackage

### rtl/core/mdsp_if.sv
// Valid/ready channel interfaces of the scatter put core

interface mdsp_req_if import mdsp_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    op;
   pos_type   pos0;
   pos_type   pos1;
   pos_type   pos2;
   pos_type   pos3;
   pos_type   pos4;
   pos_type   pos5;
   lin_type   linear_address;
   value_type value;

   modport source (output valid, op, pos0, pos1, pos2, pos3, pos4, pos5,
                   linear_address, value, input ready);
   modport sink (input valid, op, pos0, pos1, pos2, pos3, pos4, pos5,
                 linear_address, value, output ready);
endinterface

interface mdsp_rsp_if import mdsp_pkg::*; ();
   logic   valid;
   logic   ready;
   rd_type read_data;
   logic   status;

   modport source (output valid, read_data, status, input ready);
   modport sink (input valid, read_data, status, output ready);
endinterface

interface mdsp_csr_if import mdsp_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/core/multi_dim_scatter_put_core.sv
// Multi-dimensional scatter put / accumulate core with its element store
//
// Channels: req_chan carries load, scatter and read items; rsp_chan returns
// exactly one result per item, in order; csr_chan writes the six dimension
// sizes (index 0..5) and the accumulate mode (index 6).
// Each channel moves one transfer at a rising edge with valid and ready high.
// Throughput: one item per cycle while rsp ready is high and no stride
// rebuild runs. An item passes the input register, index wrap, stride
// products, offset sum with store read, then the update stage that writes
// the store and loads the result register that drives rsp valid.
// Strides are kept in registers and rebuilt after every size write, one
// multiply per cycle; req ready stays low meanwhile.
// Accumulate runs a read-modify-write; a store read that meets the write of
// the preceding item to the same element takes the written value instead.
// Reset clears the pipeline, sets every size to 1 and selects overwrite;
// the store content is undefined until written.
// When rsp valid is high and rsp ready is low the result register holds;
// earlier stages keep filling until they are full, then req ready drops.
module multi_dim_scatter_put_core import mdsp_pkg::*; #(
   parameter int DEPTH      = 4096,
   parameter int MAX_DIMS   = 6,
   parameter int ELEM_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   mdsp_req_if.sink   req_chan,
   mdsp_rsp_if.source rsp_chan,
   mdsp_csr_if.sink   csr_chan
);

`include "multi_dim_scatter_put_core_defines.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(DEPTH + 1);
   localparam int PW = SW + SIZE_W;
   localparam int MW = SW + IDX_W;
   localparam int TW = MW + 3;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [SW-1:0]         stride_type;

   typedef struct packed {
      op_type                         op;
      logic [NUM_DIMS-1:0][POS_W-1:0] pos;
      lin_type                        lin;
      value_type                      value;
   } s0_type;

   typedef struct packed {
      op_type                         op;
      lin_type                        lin;
      elem_type                       value;
      logic                           bad;
      logic [NUM_DIMS-1:0][IDX_W-1:0] ix;
   } s1_type;

   typedef struct packed {
      op_type                      op;
      lin_type                     lin;
      elem_type                    value;
      logic                        bad;
      logic [NUM_DIMS-1:0][MW-1:0] term;
   } s2_type;

   typedef struct packed {
      logic [AW-1:0] maddr;
      elem_type      value;
      logic          status;
      logic          wr;
      logic          rd;
      logic          add;
   } s3_type;

   // configuration and stride registers
   size_type    size_ff [NUM_DIMS];
   logic        accum_ff;
   stride_type  stride_ff [NUM_DIMS];
   stride_type  prod_ff;
   stride_type  prod_in;
   logic [PW-1:0] prod_mul;
   dim_idx_type cnt_ff;
   logic        busy_ff;
   logic        csr_fire;
   logic        size_wr;

   // pipeline
   logic   v0_ff, v1_ff, v2_ff, v3_ff, out_v_ff;
   logic   ld0, ld1, ld2, ld3, ld_out;
   logic   req_fire;
   s0_type s0_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   rd_type out_data_ff, out_data_in;
   logic   out_status_ff;

   // store access
   elem_type      store_ff [DEPTH];
   elem_type      rdq_ff;
   elem_type      byp_data_ff;
   logic          byp_ff;
   logic          byp_in;
   logic          rd_en;
   logic          wr_fire;
   elem_type      cur_data;
   elem_type      new_data;
   logic [TW-1:0] off_sum;

   // ---------------- configuration ----------------
   assign csr_chan.ready = 1'b1;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign size_wr  = csr_fire && (csr_chan.index < CSR_ACCUM_MODE);

   always_comb begin
      prod_mul = PW'(prod_ff) * PW'(size_ff[cnt_ff]);
      if (prod_mul >= PW'(DEPTH)) begin
         prod_in = SW'(DEPTH);
      end else begin
         prod_in = SW'(prod_mul);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIMS; i++) begin
            size_ff[i]   <= SIZE_W'(1);
            stride_ff[i] <= SW'(1);
         end
         accum_ff <= 1'b0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         prod_ff  <= SW'(1);
      end else begin
         if (csr_fire) begin
            if (size_wr) begin
               size_ff[csr_chan.index - CSR_SIZE_DIM0] <= csr_chan.wdata;
            end else if (csr_chan.index == CSR_ACCUM_MODE) begin
               accum_ff <= csr_chan.wdata[0];
            end
         end
         // rebuild strides innermost first, saturating at DEPTH
         if (size_wr) begin
            busy_ff <= 1'b1;
            cnt_ff  <= dim_idx_type'(MAX_DIMS - 1);
            prod_ff <= SW'(1);
         end else if (busy_ff) begin
            stride_ff[cnt_ff] <= prod_ff;
            prod_ff           <= prod_in;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 3'd1;
            end
         end
      end
   end

   // ---------------- flow control ----------------
   assign ld_out = !out_v_ff || rsp_chan.ready;
   assign ld3    = !v3_ff || ld_out;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;
   assign ld0    = !v0_ff || ld1;

   assign req_chan.ready = ld0 && !busy_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (ld0) begin
            v0_ff <= req_fire;
         end
         if (ld1) begin
            v1_ff <= v0_ff;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld_out) begin
            out_v_ff <= v3_ff;
         end
      end
   end

   // ---------------- stage 0: wrap and range check ----------------
   always_ff @(posedge clock) begin
      if (ld0) begin
         s0_ff.op    <= req_chan.op;
         s0_ff.pos   <= {req_chan.pos5, req_chan.pos4, req_chan.pos3,
                         req_chan.pos2, req_chan.pos1, req_chan.pos0};
         s0_ff.lin   <= req_chan.linear_address;
         s0_ff.value <= req_chan.value;
      end
   end

   always_comb begin
      logic signed [POS_W:0] pos_x;
      logic signed [POS_W:0] sz_x;
      logic signed [POS_W:0] wrapped;
      s1_in.op    = s0_ff.op;
      s1_in.lin   = s0_ff.lin;
      s1_in.value = ELEM_WIDTH'($signed(s0_ff.value));
      s1_in.bad   = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         pos_x = (POS_W + 1)'($signed(s0_ff.pos[d]));
         sz_x  = $signed({1'b0, size_ff[d]});
         if (pos_x < 0) begin
            wrapped = pos_x + sz_x;
         end else begin
            wrapped = pos_x;
         end
         if (d < MAX_DIMS) begin
            s1_in.ix[d] = IDX_W'(wrapped);
            if (wrapped < 0 || wrapped >= sz_x) begin
               s1_in.bad = 1'b1;
            end
         end else begin
            s1_in.ix[d] = '0;
         end
      end
   end

   // ---------------- stage 1: stride products ----------------
   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      s2_in.op    = s1_ff.op;
      s2_in.lin   = s1_ff.lin;
      s2_in.value = s1_ff.value;
      s2_in.bad   = s1_ff.bad;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (d < MAX_DIMS) begin
            s2_in.term[d] = MW'(s1_ff.ix[d]) * MW'(stride_ff[d]);
         end else begin
            s2_in.term[d] = '0;
         end
      end
   end

   // ---------------- stage 2: offset, status, store read ----------------
   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_ff <= s2_in;
      end
   end

   always_comb begin
      logic lin_ok;
      logic off_ok;
      off_sum = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         off_sum = off_sum + TW'(s2_ff.term[d]);
      end
      off_ok = off_sum < TW'(DEPTH);
      lin_ok = TW'(s2_ff.lin) < TW'(DEPTH);
      s3_in.value = s2_ff.value;
      s3_in.add   = 1'b0;
      unique case (s2_ff.op)
         OP_LOAD: begin
            s3_in.maddr  = AW'(s2_ff.lin);
            s3_in.status = !lin_ok;
         end
         OP_SCATTER: begin
            s3_in.maddr  = AW'(off_sum);
            s3_in.status = s2_ff.bad || !off_ok;
            s3_in.add    = accum_ff;
         end
         OP_READ: begin
            s3_in.maddr  = AW'(s2_ff.lin);
            s3_in.status = !lin_ok;
         end
         default: begin
            s3_in.maddr  = AW'(s2_ff.lin);
            s3_in.status = 1'b0;
         end
      endcase
      s3_in.wr = !s3_in.status && (s2_ff.op == OP_LOAD || s2_ff.op == OP_SCATTER);
      s3_in.rd = !s3_in.status && (s2_ff.op == OP_READ);
   end

   assign rd_en   = v2_ff && ld3;
   assign wr_fire = v3_ff && ld_out && s3_ff.wr;
   // take the value the older item writes in this same cycle
   assign byp_in  = wr_fire && (s3_ff.maddr == s3_in.maddr);

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdq_ff      <= store_ff[s3_in.maddr];
         byp_ff      <= byp_in;
         byp_data_ff <= new_data;
      end
   end

   // ---------------- stage 3: update store, load result ----------------
   always_comb begin
      cur_data = byp_ff ? byp_data_ff : rdq_ff;
      if (s3_ff.add) begin
         new_data = cur_data + s3_ff.value;
      end else begin
         new_data = s3_ff.value;
      end
      out_data_in = s3_ff.rd ? RD_W'(cur_data) : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         store_ff[s3_ff.maddr] <= new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_out) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= s3_ff.status;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.read_data = out_data_ff;
   assign rsp_chan.status    = out_status_ff;

   // ---------------- checks ----------------
   `MDSP_ASSERT_IMPL(a_busy_holds_req, busy_ff, !req_chan.ready, "item taken during stride rebuild")
   `MDSP_ASSERT_IMPL(a_status_zero_data, rsp_chan.valid && rsp_chan.status, rsp_chan.read_data == '0, "failed item returns data")
   `MDSP_ASSERT_IMPL(a_inner_stride_one, 1'b1, stride_ff[MAX_DIMS - 1] == SW'(1), "innermost stride not one")
   `MDSP_ASSERT_NEXT(a_size_write_rebuilds, size_wr, busy_ff, "size write did not start stride rebuild")

endmodule
